### design/polygon_setup_normal_centroid_bbox_defines.svh
// Assertion macros shared by the polygon setup modules.
// Depends on nothing; included by the modules that assert.
`ifndef POLYGON_SETUP_NORMAL_CENTROID_BBOX_DEFINES_SVH
`define POLYGON_SETUP_NORMAL_CENTROID_BBOX_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define PS_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// Implication checked in the cycle after the precondition.
`define PS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

### design/psn_pkg.sv
// Package for the polygon setup block: channel payloads, controller states, command and status structs.
// Depends on nothing.
`default_nettype none
package psn_pkg;
	typedef struct packed {
		logic start_polygon;
		logic signed [31:0] vertex_x;
		logic signed [31:0] vertex_y;
		logic signed [31:0] vertex_z;
		logic signed [15:0] given_normal_x;
		logic signed [15:0] given_normal_y;
		logic signed [15:0] given_normal_z;
	} vertex_t;

	typedef struct packed {
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] center_z;
		logic signed [31:0] box_min_x;
		logic signed [31:0] box_min_y;
		logic signed [31:0] box_min_z;
		logic signed [31:0] box_max_x;
		logic signed [31:0] box_max_y;
		logic signed [31:0] box_max_z;
		logic signed [15:0] face_normal_x;
		logic signed [15:0] face_normal_y;
		logic signed [15:0] face_normal_z;
	} setup_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_UPD, ST_EDGE, ST_CROSS, ST_SUM, ST_SQRT, ST_NDIV, ST_CDIV, ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic update;
		logic edge_go;
		logic cross_go;
		logic sum_go;
		logic ndiv_go;
		logic cdiv_go;
		logic out_go;
	} cmd_t;

	typedef struct packed {
		logic need_normal;
		logic busy;
		logic degenerate;
	} stat_t;
endpackage
`default_nettype wire

### design/psn_if.sv
// Valid/ready channel interface with a generic payload type.
// Depends on nothing.
`default_nettype none
interface psn_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/polygon_setup_normal_centroid_bbox.sv
// Channel   | Dir | Payload
// vtx       | in  | start_polygon, vertex_x/y/z, given_normal_x/y/z
// res       | out | center, box_min, box_max, face_normal
// Each vertex is followed by three radix-2 centroid divisions in the shared divider before the
// next vertex is accepted; the third vertex of a polygon without a given normal also runs the
// cross product, the 32-step root and three more divisions, or the cross product and root
// alone when the triangle is degenerate.
// Reset clears the vertex count, sums and normal; the result register holds until taken,
// and a waiting result holds the controller, so a new vertex is taken only once it is loaded.
`default_nettype none
module polygon_setup_normal_centroid_bbox #(
	parameter int unsigned MAX_VERTICES = 1024
) (
	input wire logic clk,
	input wire logic arst_n,
	psn_if.sink vtx,
	psn_if.source res
);
	import psn_pkg::*;
	cmd_t cmd;
	stat_t stat;
	logic signed [31:0] v [3], c [3], mn [3], mx [3];
	logic signed [15:0] n [3], fn [3];

	assign v[0] = vtx.data.vertex_x;
	assign v[1] = vtx.data.vertex_y;
	assign v[2] = vtx.data.vertex_z;
	assign n[0] = vtx.data.given_normal_x;
	assign n[1] = vtx.data.given_normal_y;
	assign n[2] = vtx.data.given_normal_z;

	psn_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(vtx.valid), .in_ready(vtx.ready),
		.out_valid(res.valid), .out_ready(res.ready), .stat(stat), .cmd(cmd)
	);

	psn_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_start(vtx.data.start_polygon), .in_v(v), .in_n(n),
		.o_center(c), .o_min(mn), .o_max(mx), .o_normal(fn)
	);

	always_ff @(posedge clk) begin
		if (cmd.out_go) begin
			res.data.center_x <= c[0];
			res.data.center_y <= c[1];
			res.data.center_z <= c[2];
			res.data.box_min_x <= mn[0];
			res.data.box_min_y <= mn[1];
			res.data.box_min_z <= mn[2];
			res.data.box_max_x <= mx[0];
			res.data.box_max_y <= mx[1];
			res.data.box_max_z <= mx[2];
			res.data.face_normal_x <= fn[0];
			res.data.face_normal_y <= fn[1];
			res.data.face_normal_z <= fn[2];
		end
	end
endmodule
`default_nettype wire

### design/psn_ctrl.sv
// Controller state machine for the polygon setup block.
// Depends on psn_pkg and the defines header.
`default_nettype none
`include "polygon_setup_normal_centroid_bbox_defines.svh"
module psn_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  wire logic out_ready,
	input  wire psn_pkg::stat_t stat,
	output psn_pkg::cmd_t cmd
);
	import psn_pkg::*;
	state_t state_q, state_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_d = ST_EDGE;
			end
			ST_EDGE: begin
				if (stat.need_normal) begin
					cmd.edge_go = 1'b1;
					state_d = ST_CROSS;
				end else begin
					cmd.cdiv_go = 1'b1;
					state_d = ST_CDIV;
				end
			end
			ST_CROSS: begin
				cmd.cross_go = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum_go = 1'b1;
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				if (!stat.busy) begin
					if (stat.degenerate) begin
						cmd.cdiv_go = 1'b1;
						state_d = ST_CDIV;
					end else begin
						cmd.ndiv_go = 1'b1;
						state_d = ST_NDIV;
					end
				end
			end
			ST_NDIV: begin
				if (!stat.busy) begin
					cmd.cdiv_go = 1'b1;
					state_d = ST_CDIV;
				end
			end
			ST_CDIV: begin
				if (!stat.busy)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_go = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`PS_ASSERT_IMP(a_ready_idle, clk, arst_n, in_ready, state_q == ST_IDLE)
	`PS_ASSERT_NEXT(a_load_upd, clk, arst_n, cmd.load, state_q == ST_UPD)
	`PS_ASSERT_NEXT(a_out_valid, clk, arst_n, cmd.out_go, out_valid_q)
endmodule
`default_nettype wire

### design/psn_dp.sv
// Datapath for the polygon setup block: box, sums, normal and shared divider.
// Depends on psn_pkg and the defines header.
`default_nettype none
`include "polygon_setup_normal_centroid_bbox_defines.svh"
module psn_dp #(
	parameter int unsigned MAX_VERTICES = 1024
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire psn_pkg::cmd_t cmd,
	output psn_pkg::stat_t stat,
	input  wire logic in_start,
	input  wire logic signed [31:0] in_v [3],
	input  wire logic signed [15:0] in_n [3],
	output logic signed [31:0] o_center [3],
	output logic signed [31:0] o_min [3],
	output logic signed [31:0] o_max [3],
	output logic signed [15:0] o_normal [3]
);
	import psn_pkg::*;
	localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
	localparam int unsigned SW = 32 + $clog2(MAX_VERTICES) + 1;

	logic [CW-1:0] count_q;
	logic signed [SW-1:0] sum_q [3];
	logic signed [31:0] min_q [3], max_q [3], first_q [6], vin_q [3];
	logic signed [15:0] nrm_q [3];
	logic known_q, acc_q;
	logic signed [32:0] e_q [6];
	logic signed [63:0] c_q [3];
	logic signed [63:0] prod_q [6];
	logic [29:0] cm_q [3];
	logic cneg_q [3];
	logic [1:0] sqstep_q;

	// Sequential helper unit: root, normal divisions, centroid divisions.
	logic busy_q, root_q;
	logic [1:0] idx_q;
	logic [6:0] bit_q;
	logic [63:0] rem_q, quo_q, den_q, root_r_q, root_x_q, root_b_q;
	logic [31:0] len_q;
	logic unit_mode_q;
	logic div_last;

	function automatic logic [63:0] magv(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	logic [63:0] emax, cmax;
	logic [5:0] ek, ck;
	always_comb begin
		emax = '0;
		for (int i = 0; i < 6; i++)
			if (magv(64'(e_q[i])) > emax)
				emax = magv(64'(e_q[i]));
		ek = '0;
		for (int k = 0; k < 4; k++)
			if ((emax >> k) >= 64'd1 << 30)
				ek = 6'(k + 1);
		cmax = '0;
		for (int i = 0; i < 3; i++)
			if (magv(c_q[i]) > cmax)
				cmax = magv(c_q[i]);
		ck = '0;
		for (int k = 0; k < 34; k++)
			if ((cmax >> k) >= 64'd1 << 30)
				ck = 6'(k + 1);
	end

	logic [63:0] sum_mag;
	assign sum_mag = magv(64'(sum_q[0]));

	assign stat.need_normal = acc_q && !known_q && count_q == CW'(3);
	assign stat.busy = busy_q || sqstep_q != 2'd0;
	assign stat.degenerate = len_q == '0;

	logic [63:0] trial;
	always_comb trial = root_r_q + root_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			known_q <= 1'b0;
			busy_q <= 1'b0;
			root_q <= 1'b0;
			sqstep_q <= '0;
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= '0;
				nrm_q[i] <= '0;
			end
		end else begin
			if (cmd.load) begin
				for (int i = 0; i < 3; i++)
					vin_q[i] <= in_v[i];
				if (in_start) begin
					count_q <= '0;
					for (int i = 0; i < 3; i++) begin
						sum_q[i] <= '0;
						nrm_q[i] <= in_n[i];
					end
					known_q <= (in_n[0] != 0) || (in_n[1] != 0) || (in_n[2] != 0);
				end
			end
			if (cmd.update) begin
				acc_q <= count_q < CW'(MAX_VERTICES);
				if (count_q < CW'(MAX_VERTICES)) begin
					for (int i = 0; i < 3; i++) begin
						if (count_q == '0 || vin_q[i] < min_q[i]) min_q[i] <= vin_q[i];
						if (count_q == '0 || vin_q[i] > max_q[i]) max_q[i] <= vin_q[i];
						sum_q[i] <= sum_q[i] + SW'(vin_q[i]);
					end
					if (count_q == '0)
						for (int i = 0; i < 3; i++) first_q[i] <= vin_q[i];
					if (count_q == CW'(1))
						for (int i = 0; i < 3; i++) first_q[3+i] <= vin_q[i];
					count_q <= count_q + 1'b1;
				end
			end
			if (cmd.edge_go) begin
				for (int i = 0; i < 3; i++) begin
					e_q[i] <= 33'(first_q[3+i]) - 33'(first_q[i]);
					e_q[3+i] <= 33'(vin_q[i]) - 33'(first_q[3+i]);
				end
			end
			if (cmd.cross_go) begin
				for (int i = 0; i < 6; i++) begin
					logic [63:0] m;
					m = magv(64'(e_q[i])) >> ek;
					e_q[i] <= e_q[i][32] ? -33'(m) : 33'(m);
				end
				sqstep_q <= '0;
			end
			if (cmd.sum_go || sqstep_q != 2'd0) begin
				case (sqstep_q)
					2'd0: begin
						prod_q[0] <= e_q[1] * e_q[5];
						prod_q[1] <= e_q[2] * e_q[4];
						prod_q[2] <= e_q[2] * e_q[3];
						prod_q[3] <= e_q[0] * e_q[5];
						prod_q[4] <= e_q[0] * e_q[4];
						prod_q[5] <= e_q[1] * e_q[3];
						sqstep_q <= 2'd1;
					end
					2'd1: begin
						c_q[0] <= prod_q[0] - prod_q[1];
						c_q[1] <= prod_q[2] - prod_q[3];
						c_q[2] <= prod_q[4] - prod_q[5];
						sqstep_q <= 2'd2;
					end
					2'd2: begin
						for (int i = 0; i < 3; i++) begin
							cm_q[i] <= 30'(magv(c_q[i]) >> ck);
							cneg_q[i] <= c_q[i][63];
						end
						sqstep_q <= 2'd3;
					end
					default: begin
						root_x_q <= 64'(cm_q[0]) * 64'(cm_q[0]) + 64'(cm_q[1]) * 64'(cm_q[1])
							+ 64'(cm_q[2]) * 64'(cm_q[2]);
						root_r_q <= '0;
						root_b_q <= 64'd1 << 62;
						root_q <= 1'b1;
						busy_q <= 1'b1;
						sqstep_q <= 2'd0;
					end
				endcase
			end
			if (busy_q && root_q) begin
				if (root_b_q == '0) begin
					root_q <= 1'b0;
					busy_q <= 1'b0;
					len_q <= 32'(root_r_q);
				end else begin
					if (root_x_q >= trial) begin
						root_x_q <= root_x_q - trial;
						root_r_q <= (root_r_q >> 1) + root_b_q;
					end else
						root_r_q <= root_r_q >> 1;
					root_b_q <= root_b_q >> 2;
				end
			end
			if (cmd.ndiv_go || cmd.cdiv_go) begin
				busy_q <= 1'b1;
				unit_mode_q <= cmd.ndiv_go;
				idx_q <= '0;
				bit_q <= 7'd64;
				if (cmd.ndiv_go) begin
					den_q <= 64'(len_q);
					rem_q <= (64'(cm_q[0]) << 14) + 64'(len_q >> 1);
				end else begin
					den_q <= 64'(count_q);
					rem_q <= sum_mag + 64'(count_q >> 1);
				end
				quo_q <= '0;
			end
			if (busy_q && !root_q && !cmd.ndiv_go && !cmd.cdiv_go) begin
				if (bit_q != 7'd0) begin
					logic [127:0] sh;
					sh = {64'd0, den_q} << (bit_q - 7'd1);
					if ({64'd0, rem_q} >= sh) begin
						rem_q <= rem_q - sh[63:0];
						quo_q <= quo_q | (64'd1 << (bit_q - 7'd1));
					end
					bit_q <= bit_q - 7'd1;
				end else begin
					if (unit_mode_q) begin
						nrm_q[idx_q] <= cneg_q[idx_q] ? -16'(quo_q) : 16'(quo_q);
						if (idx_q == 2'd2) begin
							known_q <= 1'b1;
							busy_q <= 1'b0;
						end
					end else begin
						o_center[idx_q] <= sum_q[idx_q][SW-1] ? -32'(quo_q) : 32'(quo_q);
						if (idx_q == 2'd2)
							busy_q <= 1'b0;
					end
					if (idx_q != 2'd2) begin
						idx_q <= idx_q + 2'd1;
						bit_q <= 7'd64;
						quo_q <= '0;
						if (unit_mode_q)
							rem_q <= (64'(cm_q[idx_q + 2'd1]) << 14) + 64'(len_q >> 1);
						else
							rem_q <= magv(64'(sum_q[idx_q + 2'd1])) + 64'(count_q >> 1);
					end
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			o_min[i] = min_q[i];
			o_max[i] = max_q[i];
			o_normal[i] = nrm_q[i];
		end
	end

	assign div_last = busy_q && unit_mode_q && !root_q && bit_q == 7'd0 && idx_q == 2'd2;

	`PS_ASSERT_IMP(a_count_max, clk, arst_n, 1'b1, count_q <= CW'(MAX_VERTICES))
	`PS_ASSERT_IMP(a_go_idle, clk, arst_n, cmd.cdiv_go, !busy_q)
	`PS_ASSERT_NEXT(a_known_nz, clk, arst_n, div_last, known_q)
endmodule
`default_nettype wire
